### rtl/sfrx_pkg.sv
// Shared types and constants for the serial frame receiver.
// Used by the RAM-backed datapath, the controller and the top level.
`timescale 1ns / 1ps
`default_nettype none

package sfrx_pkg;

    localparam int MAX_PAYLOAD = 32;
    localparam int STORE_DEPTH = MAX_PAYLOAD + 6;
    localparam int PTR_W       = $clog2(STORE_DEPTH);
    localparam int CNT_W       = $clog2(STORE_DEPTH + 1);

    localparam int BYTE_W      = 8;
    localparam int TICK_W      = 16;
    localparam int CFG_W       = 16;
    localparam int CFG_IDX_W   = 2;
    localparam int STATUS_W    = 2;

    // frame layout
    localparam logic [BYTE_W-1:0] SYNC0_BYTE = 8'h55;
    localparam logic [BYTE_W-1:0] SYNC1_BYTE = 8'hAA;
    localparam logic [BYTE_W-1:0] TAIL_BYTE  = 8'hF0;
    localparam int HDR_LEN      = 4;
    localparam int FRAME_EXTRA  = HDR_LEN + 2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MODULE_ADDRESS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT_TICKS  = 2'd1;

    localparam logic [BYTE_W-1:0] MODULE_ADDRESS_RST = 8'd1;
    localparam logic [TICK_W-1:0] TIMEOUT_TICKS_RST  = 16'd300;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_PAYLOAD     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY_FRAME = 2'd1;
    localparam logic [STATUS_W-1:0] ST_CHECK_ERROR = 2'd2;
    localparam logic [STATUS_W-1:0] ST_TIMEOUT     = 2'd3;

    typedef enum logic [2:0] {
        OFF_HOLD,
        OFF_CLR,
        OFF_INC,
        OFF_SET_CHK,
        OFF_SET_PAY
    } off_op_t;

    typedef struct packed {
        logic                take;
        off_op_t             off_op;
        logic                rd_en;
        logic                latch_len;
        logic                start_timer;
        logic                stop_timer;
        logic                xor_acc;
        logic                emit;
        logic [STATUS_W-1:0] emit_status;
        logic                drop_one;
        logic                drop_frame;
    } ctrl_cmd_t;

    typedef struct packed {
        logic count_ge_min;
        logic hdr_ok;
        logic hdr_last;
        logic complete;
        logic in_time;
        logic timed_out;
        logic chk_last;
        logic frame_good;
        logic len_zero;
        logic pay_last;
        logic out_free;
    } dp_stat_t;

endpackage : sfrx_pkg

`default_nettype wire

### rtl/sfrx_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module sfrx_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output      logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule : sfrx_ram

`default_nettype wire

### rtl/sfrx_dp.sv
// Datapath: circular frame store, offset/length/XOR registers, tick timer,
// configuration registers and the output register. Uses sfrx_pkg, sfrx_ram.
`timescale 1ns / 1ps
`default_nettype none

module sfrx_dp
    import sfrx_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire ctrl_cmd_t            cmd,
    output      dp_stat_t             stat,
    input  wire logic                 func,
    input  wire logic [BYTE_W-1:0]    rx_byte,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_data,
    output      logic                 out_valid,
    input  wire logic                 out_stall,
    output      logic [BYTE_W-1:0]    payload_byte,
    output      logic                 last,
    output      logic [STATUS_W-1:0]  status
);

    localparam logic [CNT_W:0]  DEPTH_W = (CNT_W + 1)'(STORE_DEPTH);
    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(STORE_DEPTH);

    logic [PTR_W-1:0]    head_reg,    head_next;
    logic [CNT_W-1:0]    count_reg,   count_next;
    logic [CNT_W-1:0]    off_reg,     off_next;
    logic [CNT_W-1:0]    len_reg;
    logic [BYTE_W-1:0]   xor_reg;
    logic                running_reg, running_next;
    logic [TICK_W-1:0]   elapsed_reg, elapsed_next;
    logic [BYTE_W-1:0]   addr_cfg_reg;
    logic [TICK_W-1:0]   timeout_cfg_reg;
    logic                out_valid_reg;
    logic [BYTE_W-1:0]   payload_reg;
    logic                last_reg;
    logic [STATUS_W-1:0] status_reg;

    logic [BYTE_W-1:0]   rd_byte;
    logic                wr_en;
    logic [PTR_W-1:0]    wr_addr;
    logic [PTR_W-1:0]    rd_addr;
    logic [CNT_W-1:0]    total;
    logic [CNT_W-1:0]    drop_n;
    logic                hdr_ok;

    // (a + b) mod STORE_DEPTH, valid while a + b < 2 * STORE_DEPTH
    function automatic logic [PTR_W-1:0] wrap_add(input logic [PTR_W-1:0] a,
                                                  input logic [CNT_W-1:0] b);
        logic [CNT_W:0] s;
        s = (CNT_W + 1)'(a) + (CNT_W + 1)'(b);
        if (s >= DEPTH_W)
        begin
            s = s - DEPTH_W;
        end
        return s[PTR_W-1:0];
    endfunction

    assign total = len_reg + CNT_W'(FRAME_EXTRA);

    always_comb
    begin
        case (cmd.off_op)
            OFF_HOLD:    off_next = off_reg;
            OFF_CLR:     off_next = '0;
            OFF_INC:     off_next = off_reg + CNT_W'(1);
            OFF_SET_CHK: off_next = CNT_W'(2);
            OFF_SET_PAY: off_next = CNT_W'(HDR_LEN);
            default:     off_next = off_reg;
        endcase
    end

    assign rd_addr = wrap_add(head_reg, off_next);
    assign wr_en   = cmd.take && !func && (count_reg < DEPTH_C);
    assign wr_addr = wrap_add(head_reg, count_reg);

    sfrx_ram #(
        .WIDTH(BYTE_W),
        .DEPTH(STORE_DEPTH)
    ) u_store (
        .clk  (clk),
        .we   (wr_en),
        .waddr(wr_addr),
        .wdata(rx_byte),
        .re   (cmd.rd_en),
        .raddr(rd_addr),
        .rdata(rd_byte)
    );

    // buffer occupancy
    always_comb
    begin
        head_next  = head_reg;
        count_next = count_reg;
        drop_n     = '0;
        if (cmd.drop_one)
        begin
            drop_n = CNT_W'(1);
        end
        else if (cmd.drop_frame)
        begin
            drop_n = total;
        end
        if (cmd.drop_one || cmd.drop_frame)
        begin
            head_next  = wrap_add(head_reg, drop_n);
            count_next = count_reg - drop_n;
        end
        else if (wr_en)
        begin
            count_next = count_reg + CNT_W'(1);
        end
    end

    // tick timer
    always_comb
    begin
        running_next = running_reg;
        elapsed_next = elapsed_reg;
        if (cmd.stop_timer)
        begin
            running_next = 1'b0;
            elapsed_next = '0;
        end
        else if (cmd.start_timer && !running_reg)
        begin
            running_next = 1'b1;
            elapsed_next = '0;
        end
        else if (cmd.take && func && running_reg && (elapsed_reg != '1))
        begin
            elapsed_next = elapsed_reg + TICK_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg        <= '0;
            count_reg       <= '0;
            running_reg     <= 1'b0;
            elapsed_reg     <= '0;
            addr_cfg_reg    <= MODULE_ADDRESS_RST;
            timeout_cfg_reg <= TIMEOUT_TICKS_RST;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            head_reg    <= head_next;
            count_reg   <= count_next;
            running_reg <= running_next;
            elapsed_reg <= elapsed_next;
            if (cfg_we && (cfg_index == REG_MODULE_ADDRESS))
            begin
                addr_cfg_reg <= cfg_data[BYTE_W-1:0];
            end
            if (cfg_we && (cfg_index == REG_TIMEOUT_TICKS))
            begin
                timeout_cfg_reg <= cfg_data[TICK_W-1:0];
            end
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge clk)
    begin
        off_reg <= off_next;
        if (cmd.latch_len)
        begin
            len_reg <= rd_byte[CNT_W-1:0];
            xor_reg <= '0;
        end
        else if (cmd.xor_acc)
        begin
            xor_reg <= xor_reg ^ rd_byte;
        end
        if (cmd.emit)
        begin
            status_reg  <= cmd.emit_status;
            payload_reg <= (cmd.emit_status == ST_PAYLOAD) ? rd_byte : '0;
            last_reg    <= (cmd.emit_status == ST_PAYLOAD) ? stat.pay_last : 1'b1;
        end
    end

    always_comb
    begin
        case (off_reg)
            CNT_W'(0): hdr_ok = (rd_byte == SYNC0_BYTE);
            CNT_W'(1): hdr_ok = (rd_byte == SYNC1_BYTE);
            CNT_W'(2): hdr_ok = (rd_byte == addr_cfg_reg);
            CNT_W'(3): hdr_ok = (rd_byte <= BYTE_W'(MAX_PAYLOAD));
            default:   hdr_ok = 1'b0;
        endcase
    end

    assign stat.hdr_ok       = hdr_ok;
    assign stat.count_ge_min = (count_reg >= CNT_W'(FRAME_EXTRA));
    assign stat.hdr_last     = (off_reg == CNT_W'(HDR_LEN - 1));
    assign stat.complete     = (count_reg >= total);
    assign stat.in_time      = (elapsed_reg <= timeout_cfg_reg);
    assign stat.timed_out    = (elapsed_reg >= timeout_cfg_reg);
    assign stat.chk_last     = (off_reg == len_reg + CNT_W'(HDR_LEN));
    assign stat.frame_good   = (xor_reg == '0) && (rd_byte == TAIL_BYTE);
    assign stat.len_zero     = (len_reg == '0);
    assign stat.pay_last     = (off_reg == len_reg + CNT_W'(HDR_LEN - 1));
    assign stat.out_free     = !out_valid_reg || !out_stall;

    assign out_valid    = out_valid_reg;
    assign payload_byte = payload_reg;
    assign last         = last_reg;
    assign status       = status_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= DEPTH_C)
        else $error("fill count above store depth");

    a_head_bound: assert property (@(posedge clk) disable iff (!rst_n)
        head_reg < PTR_W'(STORE_DEPTH))
        else $error("head pointer out of range");

    a_timer_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !running_reg |-> (elapsed_reg == '0))
        else $error("elapsed ticks nonzero while timer stopped");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall) |-> !cmd.emit)
        else $error("result overwritten while stalled");

    a_drop_fits: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.drop_frame |-> (count_reg >= total))
        else $error("frame drop larger than buffered bytes");

endmodule : sfrx_dp

`default_nettype wire

### rtl/sfrx_ctrl.sv
// Controller FSM: input handshake, header scan, checksum pass and result
// sequencing. Drives sfrx_dp through ctrl_cmd_t. Uses sfrx_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sfrx_ctrl
    import sfrx_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    output      logic      in_stall,
    input  wire dp_stat_t  stat,
    output      ctrl_cmd_t cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN,
        S_HDR,
        S_DECIDE,
        S_CHK,
        S_TAIL,
        S_PAY,
        S_EMPTY,
        S_BAD,
        S_TMO
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next      = state_reg;
        cmd             = '0;
        cmd.off_op      = OFF_HOLD;
        cmd.emit_status = ST_PAYLOAD;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.take   = 1'b1;
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (stat.count_ge_min)
                begin
                    cmd.off_op = OFF_CLR;
                    cmd.rd_en  = 1'b1;
                    state_next = S_HDR;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_HDR:
            begin
                if (!stat.hdr_ok)
                begin
                    cmd.drop_one = 1'b1;
                    state_next   = S_SCAN;
                end
                else if (stat.hdr_last)
                begin
                    cmd.latch_len   = 1'b1;
                    cmd.start_timer = 1'b1;
                    state_next      = S_DECIDE;
                end
                else
                begin
                    cmd.off_op = OFF_INC;
                    cmd.rd_en  = 1'b1;
                end
            end
            S_DECIDE:
            begin
                if (stat.complete && stat.in_time)
                begin
                    cmd.off_op = OFF_SET_CHK;
                    cmd.rd_en  = 1'b1;
                    state_next = S_CHK;
                end
                else if (stat.timed_out)
                begin
                    state_next = S_TMO;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_CHK:
            begin
                // XOR runs over address, length, payload and checksum
                cmd.xor_acc = 1'b1;
                cmd.off_op  = OFF_INC;
                cmd.rd_en   = 1'b1;
                if (stat.chk_last)
                begin
                    state_next = S_TAIL;
                end
            end
            S_TAIL:
            begin
                if (!stat.frame_good)
                begin
                    state_next = S_BAD;
                end
                else if (stat.len_zero)
                begin
                    state_next = S_EMPTY;
                end
                else
                begin
                    cmd.off_op = OFF_SET_PAY;
                    cmd.rd_en  = 1'b1;
                    state_next = S_PAY;
                end
            end
            S_PAY:
            begin
                if (stat.out_free)
                begin
                    cmd.emit        = 1'b1;
                    cmd.emit_status = ST_PAYLOAD;
                    if (stat.pay_last)
                    begin
                        cmd.stop_timer = 1'b1;
                        cmd.drop_frame = 1'b1;
                        state_next     = S_SCAN;
                    end
                    else
                    begin
                        cmd.off_op = OFF_INC;
                        cmd.rd_en  = 1'b1;
                    end
                end
            end
            S_EMPTY:
            begin
                if (stat.out_free)
                begin
                    cmd.emit        = 1'b1;
                    cmd.emit_status = ST_EMPTY_FRAME;
                    cmd.stop_timer  = 1'b1;
                    cmd.drop_frame  = 1'b1;
                    state_next      = S_SCAN;
                end
            end
            S_BAD:
            begin
                if (stat.out_free)
                begin
                    cmd.emit        = 1'b1;
                    cmd.emit_status = ST_CHECK_ERROR;
                    cmd.stop_timer  = 1'b1;
                    cmd.drop_one    = 1'b1;
                    state_next      = S_SCAN;
                end
            end
            S_TMO:
            begin
                if (stat.out_free)
                begin
                    cmd.emit        = 1'b1;
                    cmd.emit_status = ST_TIMEOUT;
                    cmd.stop_timer  = 1'b1;
                    cmd.drop_one    = 1'b1;
                    state_next      = S_SCAN;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_stall = (state_reg != S_IDLE);

    a_take_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.take |-> (state_reg == S_IDLE))
        else $error("transaction taken outside idle");

    a_scan_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.take |=> (state_reg == S_SCAN))
        else $error("no scan after input transaction");

    a_single_drop: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.drop_one && cmd.drop_frame))
        else $error("two drop commands at once");

    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> stat.out_free)
        else $error("emit while output register busy");

endmodule : sfrx_ctrl

`default_nettype wire

### rtl/serial_frame_receiver_xor_check_top.sv
// Serial frame receiver with header, address, length and XOR check; one item at a time.
// An input transaction is taken only in idle, then the scan runs before the next one is
// taken: it stops below six buffered bytes, drops one byte per rejected header position,
// checks a good header, then waits on an incomplete frame or makes the checksum pass, then
// emits the results (output stalls hold them). The frame store has a single read port.
// Reset (rst_n, async): buffer empty, timer stopped, registers 1 and 300.
`timescale 1ns / 1ps
`default_nettype none

module serial_frame_receiver_xor_check_top
    import sfrx_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output      logic                 in_stall,
    input  wire logic                 func,
    input  wire logic [BYTE_W-1:0]    rx_byte,
    output      logic                 out_valid,
    input  wire logic                 out_stall,
    output      logic [BYTE_W-1:0]    payload_byte,
    output      logic                 last,
    output      logic [STATUS_W-1:0]  status,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_data
);

    ctrl_cmd_t cmd;
    dp_stat_t  stat;

    sfrx_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .stat    (stat),
        .cmd     (cmd)
    );

    sfrx_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .func        (func),
        .rx_byte     (rx_byte),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .payload_byte(payload_byte),
        .last        (last),
        .status      (status)
    );

endmodule : serial_frame_receiver_xor_check_top

`default_nettype wire

### tb/sv/serial_frame_receiver_xor_check_top_tb.sv
// Self-checking testbench for serial_frame_receiver_xor_check_top: queued byte/tick
// stimulus, a frame-parser predictor and an in-order result scoreboard.
// Depends on sfrx_pkg and the RTL top level only.
`timescale 1ns / 1ps

module serial_frame_receiver_xor_check_top_tb;
    import sfrx_pkg::*;

    localparam int RESULTS_PER_ITEM_MAX = 64;
    localparam int CYCLE_LIMIT          = 1500000;
    localparam int SETTLE_CYCLES        = 400;
    localparam int DRAIN_LIMIT          = 200000;

    // spare register slots; writes there must be ignored
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

    typedef enum int {
        FLAW_NONE,
        FLAW_CHECKSUM,
        FLAW_TAIL,
        FLAW_ADDRESS,
        FLAW_LENGTH,
        FLAW_SYNC
    } frame_flaw_t;

    typedef struct packed {
        logic              func;
        logic [BYTE_W-1:0] rx_byte;
    } rx_item_t;

    typedef struct packed {
        logic [BYTE_W-1:0]   payload_byte;
        logic                last;
        logic [STATUS_W-1:0] status;
    } frame_result_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_stall;
    logic                 func = 1'b0;
    logic [BYTE_W-1:0]    rx_byte = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    logic [BYTE_W-1:0]    payload_byte;
    logic                 last;
    logic [STATUS_W-1:0]  status;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_data = '0;

    serial_frame_receiver_xor_check_top dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .func         (func),
        .rx_byte      (rx_byte),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .payload_byte (payload_byte),
        .last         (last),
        .status       (status),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #1 clk = ~clk;

    // stimulus and scoreboard storage
    rx_item_t      rx_pending[$];
    frame_result_t frames_expected[$];
    int unsigned   items_queued = 0;
    int unsigned   items_taken = 0;
    int unsigned   results_checked = 0;
    int unsigned   fail_count = 0;
    int unsigned   phase_count = 0;
    int unsigned   status_seen [4] = '{0, 0, 0, 0};

    // traffic shaping, written by the sequencer only; in_took is set by the sampling block
    int unsigned   send_idle_pct = 0;
    int unsigned   recv_stall_pct = 0;
    int unsigned   tick_pct = 0;
    int unsigned   hold_len = 0;
    int unsigned   hold_req = 0;
    logic [7:0]    cur_addr = MODULE_ADDRESS_RST;
    logic          in_took = 1'b0;

    // predictor state
    logic [BYTE_W-1:0] rx_store [STORE_DEPTH];
    int unsigned       rx_fill = 0;
    bit                tmr_running = 1'b0;
    logic [TICK_W-1:0] tmr_elapsed = '0;
    logic [BYTE_W-1:0] my_address = MODULE_ADDRESS_RST;
    logic [TICK_W-1:0] my_timeout = TIMEOUT_TICKS_RST;

    function automatic void store_drop(int unsigned k);
        if (k >= rx_fill)
            rx_fill = 0;
        else
        begin
            for (int i = 0; i < rx_fill - k; i++)
                rx_store[i] = rx_store[i + k];
            rx_fill -= k;
        end
    endfunction

    function automatic void expect_frame_result(logic [7:0] b, logic l, logic [1:0] s);
        frames_expected.push_back('{payload_byte: b, last: l, status: s});
    endfunction

    function automatic void timer_stop();
        tmr_running = 1'b0;
        tmr_elapsed = '0;
    endfunction

    // one accepted transaction: buffer or count, then scan until blocked
    function automatic void parse_rx(logic f, logic [BYTE_W-1:0] b);
        int          n;
        int unsigned flen;
        int unsigned ftotal;
        int unsigned need;
        logic [7:0]  x;
        bit          go;
        n = 0;
        go = 1'b1;
        if (!f)
        begin
            if (rx_fill < STORE_DEPTH)
            begin
                rx_store[rx_fill] = b;
                rx_fill++;
            end
        end
        else if (tmr_running && tmr_elapsed != 16'hFFFF)
            tmr_elapsed++;
        while (go && rx_fill >= FRAME_EXTRA)
        begin
            if (rx_store[0] != SYNC0_BYTE || rx_store[1] != SYNC1_BYTE ||
                rx_store[2] != my_address || rx_store[3] > MAX_PAYLOAD)
                store_drop(1);
            else
            begin
                flen = rx_store[3];
                ftotal = flen + FRAME_EXTRA;
                if (!tmr_running)
                begin
                    tmr_running = 1'b1;
                    tmr_elapsed = '0;
                end
                if (rx_fill >= ftotal && tmr_elapsed <= my_timeout)
                begin
                    x = '0;
                    for (int i = 2; i < flen + 5; i++)
                        x ^= rx_store[i];
                    if (x == 0 && rx_store[flen + 5] == TAIL_BYTE)
                    begin
                        need = (flen != 0) ? flen : 1;
                        if (RESULTS_PER_ITEM_MAX - n < need)
                            go = 1'b0;
                        else
                        begin
                            timer_stop();
                            if (flen == 0)
                            begin
                                expect_frame_result('0, 1'b1, ST_EMPTY_FRAME);
                                n++;
                            end
                            else
                                for (int i = 0; i < flen; i++)
                                begin
                                    expect_frame_result(rx_store[4 + i], i + 1 == flen,
                                                        ST_PAYLOAD);
                                    n++;
                                end
                            store_drop(ftotal);
                        end
                    end
                    else if (n >= RESULTS_PER_ITEM_MAX)
                        go = 1'b0;
                    else
                    begin
                        timer_stop();
                        expect_frame_result('0, 1'b1, ST_CHECK_ERROR);
                        n++;
                        store_drop(1);
                    end
                end
                else if (tmr_elapsed >= my_timeout)
                begin
                    if (n >= RESULTS_PER_ITEM_MAX)
                        go = 1'b0;
                    else
                    begin
                        timer_stop();
                        expect_frame_result('0, 1'b1, ST_TIMEOUT);
                        n++;
                        store_drop(1);
                    end
                end
                else
                    go = 1'b0;
            end
        end
    endfunction

    function automatic bit field_bad(string name, int unsigned want, int unsigned got);
        if (want != got)
        begin
            $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // sampling at the rising edge: scoreboard first, then register and input tracking
    always @(posedge clk)
    begin
        frame_result_t want;
        in_took <= rst_n && in_valid && !in_stall;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                results_checked++;
                status_seen[status]++;
                if (frames_expected.size() == 0)
                begin
                    $error("result with none expected: byte 0x%0h last %0d status %0d",
                           payload_byte, last, status);
                    fail_count++;
                end
                else
                begin
                    want = frames_expected.pop_front();
                    if (field_bad("payload_byte", want.payload_byte, payload_byte) |
                        field_bad("last", want.last, last) |
                        field_bad("status", want.status, status))
                        fail_count++;
                end
            end
            if (cfg_we)
                case (cfg_index)
                    REG_MODULE_ADDRESS: my_address = cfg_data[BYTE_W-1:0];
                    REG_TIMEOUT_TICKS:  my_timeout = cfg_data[TICK_W-1:0];
                    default: ;
                endcase
            if (in_valid && !in_stall)
            begin
                parse_rx(func, rx_byte);
                items_taken++;
            end
        end
    end

    // sender: new transaction only after the previous one went through
    always @(negedge clk)
    begin
        rx_item_t nxt;
        if (rst_n && (!in_valid || in_took))
        begin
            if (rx_pending.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                nxt = rx_pending.pop_front();
                in_valid <= 1'b1;
                func <= nxt.func;
                rx_byte <= nxt.rx_byte;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // receiver: random stall, plus a long hold-off on request
    int unsigned hold_ack = 0;
    int unsigned hold_left = 0;
    always @(negedge clk)
    begin
        if (hold_req != hold_ack)
        begin
            hold_ack = hold_req;
            hold_left = hold_len;
        end
        if (hold_left != 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    function automatic void queue_item(logic f, logic [7:0] b);
        rx_pending.push_back('{func: f, rx_byte: b});
        items_queued++;
    endfunction

    function automatic void queue_byte(logic [7:0] b);
        if (tick_pct != 0 && $urandom_range(99) < tick_pct)
            queue_item(1'b1, 8'($urandom_range(255)));
        queue_item(1'b0, b);
    endfunction

    // bias toward bytes that look like frame markers
    function automatic logic [7:0] payload_value();
        if ($urandom_range(3) != 0)
            return 8'($urandom_range(255));
        case ($urandom_range(5))
            0: return 8'h00;
            1: return 8'hFF;
            2: return SYNC0_BYTE;
            3: return SYNC1_BYTE;
            4: return TAIL_BYTE;
            default: return cur_addr;
        endcase
    endfunction

    function automatic void queue_frame(logic [7:0] addr, int unsigned len, frame_flaw_t flaw,
                                        int fill_with);
        logic [7:0]  a;
        logic [7:0]  len_field;
        logic [7:0]  chk;
        logic [7:0]  pay;
        int unsigned body;
        a = addr;
        len_field = len[7:0];
        body = len;
        if (flaw == FLAW_ADDRESS)
            a = addr ^ 8'($urandom_range(1, 255));
        if (flaw == FLAW_LENGTH)
        begin
            len_field = 8'($urandom_range(MAX_PAYLOAD + 1, 255));
            body = $urandom_range(2);
        end
        queue_byte(flaw == FLAW_SYNC ? SYNC0_BYTE ^ 8'($urandom_range(1, 255)) : SYNC0_BYTE);
        queue_byte(SYNC1_BYTE);
        queue_byte(a);
        queue_byte(len_field);
        chk = a ^ len_field;
        for (int i = 0; i < body; i++)
        begin
            pay = (fill_with >= 0) ? fill_with[7:0] : payload_value();
            chk ^= pay;
            queue_byte(pay);
        end
        if (flaw == FLAW_CHECKSUM)
            chk ^= 8'($urandom_range(1, 255));
        queue_byte(chk);
        queue_byte(flaw == FLAW_TAIL ? TAIL_BYTE ^ 8'($urandom_range(1, 255)) : TAIL_BYTE);
    endfunction

    // mostly well-formed frames, the rest broken frames, noise and tick bursts
    task automatic queue_random(int unsigned count);
        int unsigned stop_at;
        int unsigned roll;
        int unsigned len;
        stop_at = items_queued + count;
        while (items_queued < stop_at)
        begin
            roll = $urandom_range(99);
            len = ($urandom_range(7) == 0) ? $urandom_range(MAX_PAYLOAD) : $urandom_range(5);
            if (roll < 55)
                queue_frame(cur_addr, len, FLAW_NONE, -1);
            else if (roll < 65)
                queue_frame(cur_addr, len, FLAW_CHECKSUM, -1);
            else if (roll < 70)
                queue_frame(cur_addr, len, FLAW_TAIL, -1);
            else if (roll < 75)
                queue_frame(cur_addr, len, FLAW_ADDRESS, -1);
            else if (roll < 80)
                queue_frame(cur_addr, len, FLAW_LENGTH, -1);
            else if (roll < 85)
                queue_frame(cur_addr, len, FLAW_SYNC, -1);
            else if (roll < 93)
                repeat ($urandom_range(1, 3)) queue_item(1'b0, payload_value());
            else
                repeat ($urandom_range(1, 8)) queue_item(1'b1, 8'($urandom_range(255)));
        end
    endtask

    // all stimulus taken, all results in, then let a silent rescan finish
    task automatic wait_idle();
        int unsigned waited;
        while (rx_pending.size() != 0 || in_valid)
            @(posedge clk);
        waited = 0;
        while (frames_expected.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (frames_expected.size() != 0)
        begin
            $error("%0d expected results never arrived", frames_expected.size());
            fail_count++;
            frames_expected.delete();
        end
    endtask

    task automatic write_regs(logic [7:0] addr, logic [15:0] ticks);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= REG_MODULE_ADDRESS;
        cfg_data <= {8'($urandom_range(255)), addr};
        @(negedge clk);
        cfg_index <= REG_TIMEOUT_TICKS;
        cfg_data <= ticks;
        @(negedge clk);
        cfg_index <= REG_SPARE_A;
        cfg_data <= 16'($urandom_range(16'hFFFF));
        @(negedge clk);
        cfg_index <= REG_SPARE_B;
        cfg_data <= 16'($urandom_range(16'hFFFF));
        @(negedge clk);
        cfg_we <= 1'b0;
        cur_addr = addr;
        phase_count++;
    endtask

    task automatic set_traffic(int unsigned idle, int unsigned stall, int unsigned ticks);
        send_idle_pct = idle;
        recv_stall_pct = stall;
        tick_pct = ticks;
    endtask

    initial
    begin : watchdog
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset settings: tick while stopped, empty frame, one 0xFF payload, bad check
        set_traffic(0, 0, 0);
        phase_count++;
        queue_item(1'b1, 8'hFF);
        queue_frame(cur_addr, 0, FLAW_NONE, -1);
        queue_frame(cur_addr, 1, FLAW_NONE, 8'hFF);
        queue_frame(cur_addr, 0, FLAW_CHECKSUM, 8'h00);
        wait_idle();

        // short timeout on a started frame
        write_regs(MODULE_ADDRESS_RST, 16'd2);
        queue_item(1'b0, SYNC0_BYTE);
        queue_item(1'b0, SYNC1_BYTE);
        queue_item(1'b0, MODULE_ADDRESS_RST);
        queue_item(1'b0, 8'd3);
        queue_item(1'b0, 8'h11);
        queue_item(1'b0, 8'h22);
        repeat (3) queue_item(1'b1, 8'h00);
        wait_idle();

        write_regs(8'h00, 16'd1);
        set_traffic(79, 0, 3);
        queue_random(40);
        wait_idle();

        // receiver holds off while full-size frames keep coming
        write_regs(8'hFF, 16'hFFFF);
        set_traffic(0, 79, 10);
        hold_len = 600;
        hold_req++;
        repeat (2) queue_frame(cur_addr, MAX_PAYLOAD, FLAW_NONE, -1);
        queue_random(20);
        wait_idle();

        write_regs(8'($urandom_range(255)), 16'd0);
        set_traffic(6, 6, 5);
        queue_random(40);
        wait_idle();

        write_regs(8'h5A, 16'd20);
        set_traffic(0, 0, 8);
        queue_random(20);
        wait_idle();
        queue_random(20);
        wait_idle();

        write_regs(SYNC0_BYTE, 16'd5);
        set_traffic(79, 79, 6);
        queue_random(40);
        wait_idle();

        $display("Ran %0d input transactions under %0d register settings; %0d results checked.",
                 items_taken, phase_count, results_checked);
        $display("Outcomes: %0d payload, %0d empty frame, %0d check error, %0d timeout.",
                 status_seen[ST_PAYLOAD], status_seen[ST_EMPTY_FRAME],
                 status_seen[ST_CHECK_ERROR], status_seen[ST_TIMEOUT]);
        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
